// ===== design/xxh32_pkg.sv =====
// ----------------------------------------------------------------------------
// xxh32_pkg
// Shared constants, types and a helper function for the streaming 32-bit hash.
// ----------------------------------------------------------------------------
`default_nettype none

package xxh32_pkg;

    localparam logic [31:0] PRIME_ONE   = 32'd2654435761;
    localparam logic [31:0] PRIME_TWO   = 32'd2246822519;
    localparam logic [31:0] PRIME_THREE = 32'd3266489917;
    localparam logic [31:0] PRIME_FOUR  = 32'd668265263;
    localparam logic [31:0] PRIME_FIVE  = 32'h165667b1;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned HASH_W = 32;

    // operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_ROT_P4 = 2'd0,
        MUL_ACC_P1 = 2'd1,
        MUL_ACC_P2 = 2'd2,
        MUL_MIX_P3 = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     fin_mix;
        logic     emit;
    } xxh32_cmd_t;

    typedef struct packed {
        logic step_word;
        logic step_byte;
        logic last_reg;
        logic out_full;
    } xxh32_stat_t;

    function automatic logic [31:0] rotl17(input logic [31:0] v);
        rotl17 = {v[14:0], v[31:15]};
    endfunction

endpackage

`default_nettype wire

// ===== design/xxh32_ctrl.sv =====
// ----------------------------------------------------------------------------
// xxh32_ctrl
// Sequencer: steps one item through the shared multiplier and the finish.
// ----------------------------------------------------------------------------
`default_nettype none

module xxh32_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire xxh32_pkg::xxh32_stat_t stat,
    input  wire logic                  last_item,
    output xxh32_pkg::xxh32_cmd_t      cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_MUL_ROT = 7'b0000010,
        ST_MUL_P1  = 7'b0000100,
        ST_FIN_MIX = 7'b0001000,
        ST_FIN_P2  = 7'b0010000,
        ST_FIN_P3  = 7'b0100000,
        ST_FIN_OUT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = xxh32_pkg::MUL_ACC_P1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (stat.step_word)
                        state_next = ST_MUL_ROT;
                    else if (stat.step_byte)
                        state_next = ST_MUL_P1;
                    else if (last_item)
                        state_next = ST_FIN_MIX;
                end
            end
            ST_MUL_ROT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = xxh32_pkg::MUL_ROT_P4;
                state_next  = ST_MUL_P1;
            end
            ST_MUL_P1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = xxh32_pkg::MUL_ACC_P1;
                state_next  = stat.last_reg ? ST_FIN_MIX : ST_IDLE;
            end
            ST_FIN_MIX:
            begin
                cmd.fin_mix = 1'b1;
                state_next  = ST_FIN_P2;
            end
            ST_FIN_P2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = xxh32_pkg::MUL_ACC_P2;
                state_next  = ST_FIN_P3;
            end
            ST_FIN_P3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = xxh32_pkg::MUL_MIX_P3;
                state_next  = ST_FIN_OUT;
            end
            ST_FIN_OUT:
            begin
                // wait for room in the output register
                if (!stat.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    a_word_goes_rot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat.step_word) |=> (state_reg == ST_MUL_ROT))
        else $error("word step did not enter rotate multiply");
    a_rot_then_p1: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_ROT) |=> (state_reg == ST_MUL_P1))
        else $error("rotate multiply not followed by prime one multiply");
`endif

endmodule

`default_nettype wire

// ===== design/xxh32_dpath.sv =====
// ----------------------------------------------------------------------------
// xxh32_dpath
// Accumulator, word packing, shared 32x32 multiplier and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xxh32_dpath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [7:0]             data_byte,
    input  wire logic [15:0]            message_length,
    input  wire logic                   last_item,
    input  wire xxh32_pkg::xxh32_cmd_t  cmd,
    output xxh32_pkg::xxh32_stat_t      stat,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [31:0]                 hash_value
);

    logic [31:0] acc_reg,  acc_next;
    logic [31:0] idx_reg,  idx_next;
    logic [15:0] off_reg,  off_next;
    logic [23:0] pw_reg,   pw_next;
    logic [15:0] len_reg,  len_next;
    logic        last_reg, last_next;
    logic [31:0] hash_reg, hash_next;
    logic        ov_reg,   ov_next;

    logic [15:0] len_m1;
    logic [15:0] word_end;
    logic        in_win;
    logic        len_nz;
    logic [1:0]  lane;
    logic [23:0] pw_shift;
    logic [31:0] word;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] prod;
    logic [31:0] fin_h;

    // word end is 4*ceil((L-4)/4), zero for short messages
    assign len_m1   = message_length - 16'd1;
    assign word_end = (message_length > 16'd4) ? {len_m1[15:2], 2'b00} : 16'd0;
    assign in_win   = (off_reg < word_end);
    assign len_nz   = (message_length != 16'd0);
    assign lane     = off_reg[1:0];
    assign pw_shift = 24'(data_byte) << {lane, 3'b000};
    assign word     = {data_byte, pw_reg};

    assign stat.step_word = len_nz && in_win && (lane == 2'd3);
    assign stat.step_byte = len_nz && !in_win;
    assign stat.last_reg  = last_reg;
    assign stat.out_full  = ov_reg && !out_ready;

    always_comb
    begin
        case (cmd.mul_sel)
            xxh32_pkg::MUL_ROT_P4:
            begin
                mul_a = xxh32_pkg::rotl17(acc_reg);
                mul_b = xxh32_pkg::PRIME_FOUR;
            end
            xxh32_pkg::MUL_ACC_P1:
            begin
                mul_a = acc_reg;
                mul_b = xxh32_pkg::PRIME_ONE;
            end
            xxh32_pkg::MUL_ACC_P2:
            begin
                mul_a = acc_reg;
                mul_b = xxh32_pkg::PRIME_TWO;
            end
            xxh32_pkg::MUL_MIX_P3:
            begin
                mul_a = acc_reg ^ (acc_reg >> 13);
                mul_b = xxh32_pkg::PRIME_THREE;
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = xxh32_pkg::PRIME_ONE;
            end
        endcase
    end

    // only the low half of the product is ever needed
    assign prod     = mul_a * mul_b;
    assign fin_h    = acc_reg + {16'd0, len_reg};

    always_comb
    begin
        acc_next  = acc_reg;
        idx_next  = idx_reg;
        off_next  = off_reg;
        pw_next   = pw_reg;
        len_next  = len_reg;
        last_next = last_reg;
        hash_next = hash_reg;
        ov_next   = ov_reg && !out_ready;

        if (cmd.load)
        begin
            len_next  = message_length;
            last_next = last_item;
            if (len_nz)
            begin
                off_next = off_reg + 16'd1;
                if (in_win)
                begin
                    if (lane == 2'd3)
                    begin
                        acc_next = acc_reg + word + idx_reg;
                        idx_next = idx_reg + 32'd1;
                        pw_next  = '0;
                    end
                    else
                    begin
                        pw_next = pw_reg | pw_shift;
                    end
                end
                else
                begin
                    acc_next = acc_reg + {24'd0, data_byte} + idx_reg;
                    idx_next = idx_reg + 32'd1;
                end
            end
        end

        if (cmd.mul_en)
            acc_next = (cmd.mul_sel == xxh32_pkg::MUL_ROT_P4) ? (acc_reg + prod) : prod;

        if (cmd.fin_mix)
            acc_next = fin_h ^ (fin_h >> 15);

        if (cmd.emit)
        begin
            hash_next = acc_reg ^ (acc_reg >> 16);
            ov_next   = 1'b1;
            acc_next  = xxh32_pkg::PRIME_FIVE;
            idx_next  = xxh32_pkg::PRIME_ONE;
            off_next  = '0;
            pw_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= xxh32_pkg::PRIME_FIVE;
            idx_reg  <= xxh32_pkg::PRIME_ONE;
            off_reg  <= '0;
            pw_reg   <= '0;
            last_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            idx_reg  <= idx_next;
            off_reg  <= off_next;
            pw_reg   <= pw_next;
            last_reg <= last_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        hash_reg <= hash_next;
    end

    assign out_valid  = ov_reg;
    assign hash_value = hash_reg;

`ifndef ASSERT_OFF
    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("emitted hash not presented");
    a_emit_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (acc_reg == xxh32_pkg::PRIME_FIVE && off_reg == 16'd0
                      && idx_reg == xxh32_pkg::PRIME_ONE && pw_reg == 24'd0))
        else $error("state not returned to start values after finish");
    a_no_emit_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid && !out_ready))
        else $error("hash overwritten while waiting");
`endif

endmodule

`default_nettype wire

// ===== design/xxfast_hash32_stream_unit.sv =====
// ----------------------------------------------------------------------------
// xxfast_hash32_stream_unit
// Streaming 32-bit xxFAST hash, one message byte per input item.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid, in_ready  | data_byte, message_length, last_item
//  out     | out_valid, out_ready| hash_value
//
//  a byte packed into a word is only stored, a byte step makes one multiply, and a
//  completed word makes two passes through the single shared 32x32 multiplier
//  the last item adds the finish: mix, two multiplies, output load
//  in_ready is high only while the sequencer waits for an item
//  the output register holds the hash until taken; a new message can be
//  hashed meanwhile, its finish waits for the register to empty
//  reset puts the accumulator and index at their start values at once
// ----------------------------------------------------------------------------
`default_nettype none

module xxfast_hash32_stream_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] message_length,
    input  wire logic        last_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value
);

    xxh32_pkg::xxh32_cmd_t  cmd;
    xxh32_pkg::xxh32_stat_t stat;

    xxh32_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .stat      (stat),
        .last_item (last_item),
        .cmd       (cmd)
    );

    xxh32_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .message_length (message_length),
        .last_item      (last_item),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value)
    );

endmodule

`default_nettype wire
